### sv/cdq_pkg.sv
// cdq_pkg: request codes, widths, controller states and memory control type
// shared by the circular deque modules
// no dependencies
package cdq_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 11;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

  // reported as front and rear value when the deque is empty
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

### sv/cdq_in_if.sv
// cdq_in_if: request channel of the circular deque, valid/ready with payload
// depends on cdq_pkg
interface cdq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::REQ_W-1:0]            req_type;
  logic signed [cdq_pkg::DATA_W-1:0]    push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

### sv/cdq_out_if.sv
// cdq_out_if: result channel of the circular deque, valid/ready with payload
// depends on cdq_pkg
interface cdq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 success;
  logic signed [cdq_pkg::DATA_W-1:0]    front_value;
  logic signed [cdq_pkg::DATA_W-1:0]    rear_value;
  logic                                 now_empty;
  logic                                 now_full;

  modport source (output valid, success, front_value, rear_value, now_empty, now_full,
                  input ready);
  modport sink   (input valid, success, front_value, rear_value, now_empty, now_full,
                  output ready);
endinterface

### sv/circular_deque.sv
// circular_deque: ring-buffer double-ended queue with a capacity register
// sequence: a push is written to the entry store when its beat is accepted, then the
// head and tail entries are read, then the result is loaded into the output
// register once it is free; no new request is taken before that load, but a
// result may wait in the output register while the next request is taken
// reset: head, tail and count cleared, capacity min(1024, DEPTH); store not cleared
module circular_deque #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cdq_pkg::CFG_W-1:0] cfg_wdata,
  cdq_in_if.sink                    in_ch,
  cdq_out_if.source                 out_ch
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cdq_pkg::ram_ctl_t                 ram_ctl;
  logic [AW-1:0]                     ram_waddr;
  logic [AW-1:0]                     ram_raddr_a;
  logic [AW-1:0]                     ram_raddr_b;
  logic signed [cdq_pkg::DATA_W-1:0] ram_rdata_a;
  logic signed [cdq_pkg::DATA_W-1:0] ram_rdata_b;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_ctl     (ram_ctl),
    .ram_waddr   (ram_waddr),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  cdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .waddr   (ram_waddr),
    .wdata   (in_ch.push_value),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

endmodule

### sv/cdq_ram.sv
// cdq_ram: entry store, one write port and two registered read ports
// depends on cdq_pkg
module cdq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                              clk,
  input  cdq_pkg::ram_ctl_t                 ctl,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [cdq_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr_a,
  input  logic [AW-1:0]                     raddr_b,
  output logic signed [cdq_pkg::DATA_W-1:0] rdata_a,
  output logic signed [cdq_pkg::DATA_W-1:0] rdata_b
);

  logic signed [cdq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### sv/cdq_ctrl.sv
// cdq_ctrl: head/tail/count update, capacity register, sequencer and
// output register of the circular deque; drives the entry store in cdq_ram
// depends on cdq_pkg, cdq_in_if, cdq_out_if
module cdq_ctrl #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned CW    = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cdq_pkg::CFG_W-1:0]         cfg_wdata,
  cdq_in_if.sink                            in_ch,
  cdq_out_if.source                         out_ch,
  output cdq_pkg::ram_ctl_t                 ram_ctl,
  output logic [AW-1:0]                     ram_waddr,
  output logic [AW-1:0]                     ram_raddr_a,
  output logic [AW-1:0]                     ram_raddr_b,
  input  logic signed [cdq_pkg::DATA_W-1:0] ram_rdata_a,
  input  logic signed [cdq_pkg::DATA_W-1:0] ram_rdata_b
);

  localparam int unsigned CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

  cdq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cap_r, cap_nxt;
  logic            ok_r, ok_nxt;
  logic            load_out;
  logic            out_valid_r;
  logic            success_r;
  logic signed [cdq_pkg::DATA_W-1:0] front_r;
  logic signed [cdq_pkg::DATA_W-1:0] rear_r;
  logic            empty_r;
  logic            full_r;
  logic [CW-1:0]   cap_m1;
  logic [AW-1:0]   last_idx;
  logic            is_empty;
  logic            is_full;

  assign cap_m1   = cap_r - CW'(1);
  assign last_idx = AW'(cap_m1);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == cap_r);

  assign ram_raddr_a = head_r;
  assign ram_raddr_b = tail_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    ok_nxt        = ok_r;
    ram_ctl       = '0;
    ram_waddr     = head_r;
    in_ch.ready   = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      cdq_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = cdq_pkg::ST_READ;
          unique case (in_ch.req_type) inside
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK: begin
              ok_nxt = !is_full;
              if (!is_full) begin
                ram_ctl.we = 1'b1;
                count_nxt  = count_r + CW'(1);
                if (is_empty) begin
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  ram_waddr = '0;
                end else if (in_ch.req_type == cdq_pkg::REQ_PUSH_FRONT) begin
                  head_nxt  = (head_r == '0) ? last_idx : head_r - AW'(1);
                  ram_waddr = head_nxt;
                end else begin
                  tail_nxt  = (tail_r == last_idx) ? '0 : tail_r + AW'(1);
                  ram_waddr = tail_nxt;
                end
              end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_BACK: begin
              ok_nxt = !is_empty;
              if (!is_empty) begin
                if (count_r == CW'(1)) begin
                  // last entry gone: back to slot zero
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  count_nxt = '0;
                end else begin
                  count_nxt = count_r - CW'(1);
                  if (in_ch.req_type == cdq_pkg::REQ_POP_FRONT) begin
                    head_nxt = (head_r == last_idx) ? '0 : head_r + AW'(1);
                  end else begin
                    tail_nxt = (tail_r == '0) ? last_idx : tail_r - AW'(1);
                  end
                end
              end
            end
            cdq_pkg::REQ_QUERY: begin
              ok_nxt = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      cdq_pkg::ST_READ: begin
        ram_ctl.re = 1'b1;
        state_nxt  = cdq_pkg::ST_LOAD;
      end
      cdq_pkg::ST_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::ST_IDLE;
      end
    endcase
    // capacity write empties the deque
    if (cfg_we) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      if (cfg_wdata == '0) begin
        cap_nxt = CW'(1);
      end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
        cap_nxt = CW'(DEPTH);
      end else begin
        cap_nxt = CW'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= CW'(CAP_RST);
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      ok_r    <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      success_r <= ok_r;
      front_r   <= is_empty ? cdq_pkg::EMPTY_VALUE : ram_rdata_a;
      rear_r    <= is_empty ? cdq_pkg::EMPTY_VALUE : ram_rdata_b;
      empty_r   <= is_empty;
      full_r    <= is_full;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.success     = success_r;
  assign out_ch.front_value = front_r;
  assign out_ch.rear_value  = rear_r;
  assign out_ch.now_empty   = empty_r;
  assign out_ch.now_full    = full_r;

  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count above capacity");

  a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r) < cap_r) && (CW'(tail_r) < cap_r))
    else $error("head or tail outside the ring");

  a_empty_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    is_empty |-> (head_r == '0) && (tail_r == '0))
    else $error("empty deque with pointers off slot zero");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> ram_ctl.re)
    else $error("accepted beat not followed by a store read");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && empty_r |-> (front_r == cdq_pkg::EMPTY_VALUE) &&
                               (rear_r == cdq_pkg::EMPTY_VALUE))
    else $error("empty result carries stored values");

endmodule

### bench/tb.sv
// tb: self-checking bench for circular_deque, random requests over many capacities
// depends on cdq_pkg, cdq_in_if, cdq_out_if and circular_deque
`timescale 1ns / 1ps

typedef struct {
  logic        success;
  logic [31:0] front_value;
  logic [31:0] rear_value;
  logic        now_empty;
  logic        now_full;
} deque_view_t;

class deque_tracker;
  logic [31:0]  slots [1024];
  int unsigned  head;
  int unsigned  tail;
  int unsigned  count;
  logic [10:0]  capacity;
  deque_view_t  expected_views [$];
  int           requests;
  int           checked;
  int           mismatches;

  function new();
    head = 0;
    tail = 0;
    count = 0;
    capacity = 11'd1024;
    requests = 0;
    checked = 0;
    mismatches = 0;
  endfunction

  function int unsigned usable_slots();
    if (capacity == 0) return 1;
    if (capacity > 1024) return 1024;
    return 32'(capacity);
  endfunction

  // a capacity write also empties the deque
  function void set_capacity(logic [10:0] value);
    capacity = value;
    head = 0;
    tail = 0;
    count = 0;
  endfunction

  function int pending();
    return expected_views.size();
  endfunction

  function void note_request(logic [2:0] req, logic [31:0] value);
    deque_view_t view;
    int unsigned cap;
    cap = usable_slots();
    view.success = 1'b0;
    case (req)
      cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK: begin
        if (count < cap) begin
          if (count == 0) begin
            head = 0;
            tail = 0;
            slots[0] = value;
          end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
            head = (head == 0) ? cap - 1 : head - 1;
            slots[head] = value;
          end else begin
            tail = (tail == cap - 1) ? 0 : tail + 1;
            slots[tail] = value;
          end
          count++;
          view.success = 1'b1;
        end
      end
      cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_BACK: begin
        if (count != 0) begin
          if (count == 1) begin
            head = 0;
            tail = 0;
            count = 0;
          end else begin
            if (req == cdq_pkg::REQ_POP_FRONT) head = (head == cap - 1) ? 0 : head + 1;
            else tail = (tail == 0) ? cap - 1 : tail - 1;
            count--;
          end
          view.success = 1'b1;
        end
      end
      cdq_pkg::REQ_QUERY: view.success = 1'b1;
      default: view.success = 1'b0;
    endcase
    view.front_value = (count == 0) ? cdq_pkg::EMPTY_VALUE : slots[head];
    view.rear_value  = (count == 0) ? cdq_pkg::EMPTY_VALUE : slots[tail];
    view.now_empty   = (count == 0);
    view.now_full    = (count == cap);
    expected_views.push_back(view);
    requests++;
  endfunction

  function void check_result(deque_view_t seen);
    deque_view_t want;
    if (expected_views.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat: success %0b front %h rear %h",
                                     seen.success, seen.front_value, seen.rear_value);
      return;
    end
    want = expected_views.pop_front();
    checked++;
    if (seen.success !== want.success || seen.front_value !== want.front_value ||
        seen.rear_value !== want.rear_value || seen.now_empty !== want.now_empty ||
        seen.now_full !== want.now_full) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d mismatch: expected ok %0b front %h rear %h empty %0b full %0b",
                 checked, want.success, want.front_value, want.rear_value,
                 want.now_empty, want.now_full);
        $display("result %0d mismatch: actual   ok %0b front %h rear %h empty %0b full %0b",
                 checked, seen.success, seen.front_value, seen.rear_value,
                 seen.now_empty, seen.now_full);
      end
    end
  endfunction
endclass

module tb;

  localparam int unsigned DEPTH = 1024;
  localparam int          CYCLE_LIMIT = 1000000;
  // codes with no operation behind them
  localparam logic [cdq_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [cdq_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [cdq_pkg::REQ_W-1:0] REQ_TOP     = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [cdq_pkg::CFG_W-1:0] cfg_wdata;
  int                        cycles;
  int                        cfg_writes;
  int                        stall_left;
  bit                        calm;
  deque_tracker              tracker;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, tracker.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, one ready update per edge
  initial begin
    deque_view_t seen;
    out_ch.ready = 1'b0;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        seen.success     = out_ch.success;
        seen.front_value = out_ch.front_value;
        seen.rear_value  = out_ch.rear_value;
        seen.now_empty   = out_ch.now_empty;
        seen.now_full    = out_ch.now_full;
        tracker.check_result(seen);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [cdq_pkg::REQ_W-1:0] req, input logic [31:0] value);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.push_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_request(req, value);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [cdq_pkg::CFG_W-1:0] value);
    drain_results();
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(value);
    cfg_writes++;
  endtask

  // pushes and pops alternate in bias so the deque swings between empty and full
  task automatic run_mix(input int n, input int fill_pct, input int drain_pct);
    int                        seg_left;
    bit                        filling;
    int                        r;
    logic [cdq_pkg::REQ_W-1:0] req;
    seg_left = 0;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (seg_left == 0) begin
        filling  = !filling;
        seg_left = $urandom_range(4, 2 * tracker.usable_slots() + 8);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < 3) req = 3'($urandom_range(cdq_pkg::REQ_QUERY + 1, REQ_TOP));
      else if (r < 8) req = cdq_pkg::REQ_QUERY;
      else if ($urandom_range(0, 99) < (filling ? fill_pct : drain_pct))
        req = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_BACK : cdq_pkg::REQ_PUSH_FRONT;
      else
        req = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_BACK : cdq_pkg::REQ_POP_FRONT;
      send_request(req, pick_value());
      if (i == n / 2) drain_results();
    end
  endtask

  initial begin
    int caps [9];
    int sizes [9];
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cfg_writes = 0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = cdq_pkg::REQ_QUERY;
    in_ch.push_value = '0;
    tracker = new();
    caps  = '{1, 2, 3, 5, 8, 16, 63, 1024, 1023};
    sizes = '{40, 60, 60, 80, 80, 90, 60, 30, 30};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty pops, odd codes, front wrap, extreme values
    send_request(cdq_pkg::REQ_POP_FRONT, 32'h1234_5678);
    send_request(cdq_pkg::REQ_POP_BACK, 32'h0);
    send_request(cdq_pkg::REQ_QUERY, 32'h0);
    send_request(REQ_SPARE_A, 32'h0);
    send_request(REQ_TOP, 32'h0);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'hffff_ffff);
    send_request(REQ_SPARE_B, 32'h0);
    send_request(cdq_pkg::REQ_QUERY, 32'h0);
    send_request(cdq_pkg::REQ_POP_FRONT, 32'h0);
    send_request(cdq_pkg::REQ_POP_BACK, 32'h0);
    send_request(cdq_pkg::REQ_POP_FRONT, 32'h0);
    send_request(cdq_pkg::REQ_POP_BACK, 32'h0);
    send_request(cdq_pkg::REQ_POP_BACK, 32'h0);

    // zero capacity acts as one slot
    write_capacity(11'd0);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'h5a5a_a5a5);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h0f0f_f0f0);
    send_request(cdq_pkg::REQ_POP_FRONT, 32'h0);
    send_request(cdq_pkg::REQ_POP_FRONT, 32'h0);

    for (int p = 0; p < 9; p++) begin
      write_capacity(11'(caps[p]));
      calm = ($urandom_range(0, 3) == 0);
      run_mix(sizes[p], 75, 25);
    end

    write_capacity(11'($urandom_range(1, DEPTH)));
    calm = 1'b0;
    run_mix(60, 70, 30);

    // oversized capacity clamps to the full ring
    write_capacity(11'h7ff);
    calm = 1'b1;
    run_mix(60, 94, 94);
    calm = 1'b0;
    run_mix(30, 6, 6);

    drain_results();
    repeat (12) @(posedge clk);
    $display("%0d requests over %0d capacity writes, %0d results checked, %0d mismatches",
             tracker.requests, cfg_writes, tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### files.f
sv/cdq_pkg.sv
sv/cdq_in_if.sv
sv/cdq_out_if.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
bench/tb.sv
